### hw/rtl/sync_crc16_frame_deframer_core_defines.svh
// assertion macros shared by the checker
`ifndef SYNC_CRC16_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_CRC16_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define SFD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfd: implication failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfd: next-cycle check failed");

// signal held while the transfer is stalled
`define SFD_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ((vld) && !(rdy)) |=> $stable(sig)) \
        else $error("sfd: value changed while stalled");

`endif

### hw/rtl/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    // body byte positions
    localparam logic [2:0] IDX_SEQ    = 3'd0;
    localparam logic [2:0] IDX_TEMP_0 = 3'd1;
    localparam logic [2:0] IDX_TEMP_3 = 3'd4;
    localparam logic [2:0] IDX_CRC_LO = 3'd5;
    localparam logic [2:0] IDX_LAST   = 3'd6;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_beat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/sfd_in_stage.sv
module sfd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output sfd_pkg::byte_beat_t beat,
    input  logic                beat_ready
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_ready = !valid_reg || beat_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (beat_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

### hw/rtl/sfd_frame_core.sv
module sfd_frame_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfd_pkg::byte_beat_t beat,
    output logic                beat_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_frame_status,
    output logic [7:0]          m_frame_seq,
    output logic [31:0]         m_temp_word,
    output logic [7:0]          m_drop_total,
    output logic                m_link_up
);

    logic [7:0]  prev_reg, prev_next;
    logic        in_body_reg, in_body_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] temp_reg, temp_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  exp_reg, exp_next;
    logic [7:0]  drops_reg, drops_next;
    logic [31:0] good_reg, good_next;
    logic        link_reg, link_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_status_reg;
    logic [7:0]  out_seq_reg;
    logic [31:0] out_temp_reg;
    logic [7:0]  out_drops_reg;
    logic        out_link_reg;

    logic        frame_end;
    logic        consume;
    logic        emit;
    logic        crc_ok;
    logic [1:0]  lane;
    logic [7:0]  b;

    assign b         = beat.data;
    assign frame_end = in_body_reg && (count_reg >= sfd_pkg::IDX_LAST);
    assign beat_ready = !frame_end || !out_valid_reg || m_ready;
    assign consume   = beat.valid && beat_ready;
    assign emit      = consume && frame_end;
    assign crc_ok    = ({b, crc_lo_reg} == crc_reg);
    assign lane      = 2'(count_reg - sfd_pkg::IDX_TEMP_0);

    always_comb begin
        prev_next    = prev_reg;
        in_body_next = in_body_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        seq_next     = seq_reg;
        temp_next    = temp_reg;
        crc_lo_next  = crc_lo_reg;
        exp_next     = exp_reg;
        drops_next   = drops_reg;
        good_next    = good_reg;
        link_next    = link_reg;
        if (consume) begin
            if (!in_body_reg) begin
                if (prev_reg == sfd_pkg::SYNC_FIRST && b == sfd_pkg::SYNC_SECOND) begin
                    in_body_next = 1'b1;
                    count_next   = sfd_pkg::IDX_SEQ;
                    crc_next     = sfd_pkg::CRC_INIT;
                end else begin
                    prev_next = b;
                end
            end else if (frame_end) begin
                if (crc_ok) begin
                    good_next  = temp_reg;
                    drops_next = drops_reg + (seq_reg - exp_reg);
                    link_next  = 1'b1;
                    exp_next   = seq_reg + 8'd1;
                end
                in_body_next = 1'b0;
                count_next   = sfd_pkg::IDX_SEQ;
                prev_next    = 8'h00;
                crc_next     = sfd_pkg::CRC_INIT;
            end else begin
                if (count_reg == sfd_pkg::IDX_SEQ) begin
                    seq_next = b;
                    crc_next = sfd_pkg::crc_byte(crc_reg, b);
                end else if (count_reg <= sfd_pkg::IDX_TEMP_3) begin
                    temp_next[lane*8 +: 8] = b;
                    crc_next = sfd_pkg::crc_byte(crc_reg, b);
                end else begin
                    crc_lo_next = b;
                end
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= 8'h00;
            in_body_reg   <= 1'b0;
            count_reg     <= sfd_pkg::IDX_SEQ;
            crc_reg       <= sfd_pkg::CRC_INIT;
            seq_reg       <= 8'h00;
            temp_reg      <= 32'h0;
            crc_lo_reg    <= 8'h00;
            exp_reg       <= 8'h00;
            drops_reg     <= 8'h00;
            good_reg      <= 32'h0;
            link_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            in_body_reg   <= in_body_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            seq_reg       <= seq_next;
            temp_reg      <= temp_next;
            crc_lo_reg    <= crc_lo_next;
            exp_reg       <= exp_next;
            drops_reg     <= drops_next;
            good_reg      <= good_next;
            link_reg      <= link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_status_reg <= crc_ok ? sfd_pkg::STATUS_OK : sfd_pkg::STATUS_BAD;
            out_seq_reg    <= seq_reg;
            out_temp_reg   <= good_next;
            out_drops_reg  <= drops_next;
            out_link_reg   <= link_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_status = out_status_reg;
    assign m_frame_seq    = out_seq_reg;
    assign m_temp_word    = out_temp_reg;
    assign m_drop_total   = out_drops_reg;
    assign m_link_up      = out_link_reg;

endmodule

### hw/rtl/sync_crc16_frame_deframer_core.sv
// Sync-word deframer with CRC-16/CCITT-FALSE check, one byte per transfer.
// Input channel s_valid/s_ready/s_rx_byte carries received bytes. The block hunts
// for 0xAA followed by 0x55, then takes seven body bytes: sequence number, four
// temperature bytes (first one least significant) and the CRC, low byte first.
// Result channel m_valid/m_ready carries one transfer per frame: status (0 good,
// 1 CRC mismatch), the frame's sequence byte, and the stored temperature word,
// drop total and link flag after the frame has been applied.
// Throughput: one byte per cycle while no waiting result is stalled; the CRC byte
// update is combinational from the input register to the frame state registers.
// The last body byte waits in the input register; m_valid rises when it leaves that
// register and the result is loaded into the output registers.
// Reset (aresetn low, synchronous) empties both registers, returns to hunting,
// and clears the stored temperature, drop total, expected sequence and link flag.
// While the receiver stalls a waiting result, bytes that end no frame keep
// being taken; a byte that would end the next frame waits in the input register.
module sync_crc16_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_status,
    output logic [7:0]  m_frame_seq,
    output logic [31:0] m_temp_word,
    output logic [7:0]  m_drop_total,
    output logic        m_link_up
);

    sfd_pkg::byte_beat_t beat;
    logic                beat_ready;

    sfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .beat       (beat),
        .beat_ready (beat_ready)
    );

    sfd_frame_core u_frame_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .beat           (beat),
        .beat_ready     (beat_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_frame_seq    (m_frame_seq),
        .m_temp_word    (m_temp_word),
        .m_drop_total   (m_drop_total),
        .m_link_up      (m_link_up)
    );

endmodule

### hw/rtl/sfd_checker.sv
`include "sync_crc16_frame_deframer_core_defines.svh"

module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_frame_status,
    input logic [7:0]  m_frame_seq,
    input logic [31:0] m_temp_word,
    input logic [7:0]  m_drop_total,
    input logic        m_link_up
);

    // a stalled result stays up
    `SFD_ASSERT_NEXT(a_out_valid_held, aclk, aresetn, m_valid && !m_ready, m_valid)
    // a stalled result keeps its fields
    `SFD_ASSERT_HOLD(a_out_held, aclk, aresetn, m_valid, m_ready,
        {m_frame_status, m_frame_seq, m_temp_word, m_drop_total, m_link_up})
    // a good frame always reports the link as up
    `SFD_ASSERT_IMPLY(a_good_link, aclk, aresetn,
        m_valid && (m_frame_status == sfd_pkg::STATUS_OK), m_link_up)
    // the link flag never drops once reported
    `SFD_ASSERT_NEXT(a_link_sticky, aclk, aresetn, m_valid && m_link_up, !m_valid || m_link_up)
    // with no result waiting the input is always open
    `SFD_ASSERT_IMPLY(a_ready_when_idle, aclk, aresetn, !m_valid, s_ready)

endmodule

bind sync_crc16_frame_deframer_core sfd_checker u_sfd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_status (m_frame_status),
    .m_frame_seq    (m_frame_seq),
    .m_temp_word    (m_temp_word),
    .m_drop_total   (m_drop_total),
    .m_link_up      (m_link_up)
);
